@@ rtl/heading_pi_differential_drive_core_defines.svh @@
// Assertion macros for the heading PI controller core.
// Included by RTL files that carry checks; needs clk and rst_n in scope.
`ifndef HEADING_PI_DIFFERENTIAL_DRIVE_CORE_DEFINES_SVH
`define HEADING_PI_DIFFERENTIAL_DRIVE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HPDD_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hpdd: same-cycle check failed");
// next-cycle implication
`define HPDD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hpdd: next-cycle check failed");
`else
`define HPDD_ASSERT_IMPL(lbl, pre, post)
`define HPDD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/hpdd_pkg.sv @@
// Shared types, constants and microcode ROM for the heading PI core.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package hpdd_pkg;

    // fixed point: angles carry 6 fraction bits, gains are Q8.8
    localparam int ANG_FRAC     = 6;
    localparam int PERIOD_FX    = 360 * (1 << ANG_FRAC);
    localparam int HALF_FX      = 180 * (1 << ANG_FRAC);
    localparam int DEADBAND_FX  = 5 * (1 << ANG_FRAC);
    localparam int INT_LIMIT_FX = 65000 * 256;
    localparam int CORR_LIMIT   = 131040;
    localparam int PWM_TOP      = 65520;
    // multiple of 360 that makes any reduced heading word non-negative
    localparam int MOD_OFFSET   = 360 * 65536;
    localparam int MOD_DIVISOR  = 360;
    // floor(x / 360) = (x * MOD_RECIP) >> MOD_SHIFT, exact for x < 2^25
    localparam int MOD_SHIFT    = 33;
    localparam logic [24:0] MOD_RECIP = 25'd23860930;
    localparam int DIV_STEPS    = 32;

    // register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROPORTIONAL_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY         = 2'd3;

    // drive direction codes (any negative code is reverse)
    localparam logic [1:0] DIR_FWD  = 2'b01;
    localparam logic [1:0] DIR_NONE = 2'b00;

    typedef struct packed {
        logic [15:0] distance_gain;
        logic [15:0] integral_gain;
        logic [15:0] proportional_gain;
        logic [15:0] base_duty;
    } cfg_regs_t;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_MUL_D,
        OP_RAW,
        OP_MOD_START,
        OP_MOD_REM,
        OP_NOP,
        OP_WRAP,
        OP_MUL_I,
        OP_ACC,
        OP_DIV_START,
        OP_ITERM,
        OP_MUL_P,
        OP_SUM,
        OP_CORR,
        OP_MIX
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_DIV_BUSY,
        COND_DEADBAND,
        COND_OUT_FULL
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_MUL_D     = 4'd1;
    localparam step_t STEP_RAW       = 4'd2;
    localparam step_t STEP_MOD_START = 4'd3;
    localparam step_t STEP_MOD_REM   = 4'd4;
    localparam step_t STEP_WRAP      = 4'd5;
    localparam step_t STEP_MUL_I     = 4'd6;
    localparam step_t STEP_ACC       = 4'd7;
    localparam step_t STEP_DIV_START = 4'd8;
    localparam step_t STEP_DIV_WAIT  = 4'd9;
    localparam step_t STEP_ITERM     = 4'd10;
    localparam step_t STEP_MUL_P     = 4'd11;
    localparam step_t STEP_SUM       = 4'd12;
    localparam step_t STEP_CORR      = 4'd13;
    localparam step_t STEP_OUT_WAIT  = 4'd14;
    localparam step_t STEP_MIX       = 4'd15;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic item_valid;
        logic div_busy;
        logic deadband;
        logic out_full;
    } stat_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] quotient;
    } div_rsp_t;

    // control program: one word per step, jump taken when cond holds
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
        case (s)
            STEP_IDLE:      w = '{op: OP_LOAD,      cond: COND_NO_ITEM,  target: STEP_IDLE};
            STEP_MUL_D:     w = '{op: OP_MUL_D,     cond: COND_NEVER,    target: STEP_IDLE};
            STEP_RAW:       w = '{op: OP_RAW,       cond: COND_NEVER,    target: STEP_IDLE};
            STEP_MOD_START: w = '{op: OP_MOD_START, cond: COND_NEVER,    target: STEP_IDLE};
            STEP_MOD_REM:   w = '{op: OP_MOD_REM,   cond: COND_NEVER,    target: STEP_IDLE};
            STEP_WRAP:      w = '{op: OP_WRAP,      cond: COND_NEVER,    target: STEP_IDLE};
            STEP_MUL_I:     w = '{op: OP_MUL_I,     cond: COND_NEVER,    target: STEP_IDLE};
            STEP_ACC:       w = '{op: OP_ACC,       cond: COND_DEADBAND, target: STEP_MUL_P};
            STEP_DIV_START: w = '{op: OP_DIV_START, cond: COND_NEVER,    target: STEP_IDLE};
            STEP_DIV_WAIT:  w = '{op: OP_NOP,       cond: COND_DIV_BUSY, target: STEP_DIV_WAIT};
            STEP_ITERM:     w = '{op: OP_ITERM,     cond: COND_NEVER,    target: STEP_IDLE};
            STEP_MUL_P:     w = '{op: OP_MUL_P,     cond: COND_NEVER,    target: STEP_IDLE};
            STEP_SUM:       w = '{op: OP_SUM,       cond: COND_NEVER,    target: STEP_IDLE};
            STEP_CORR:      w = '{op: OP_CORR,      cond: COND_NEVER,    target: STEP_IDLE};
            STEP_OUT_WAIT:  w = '{op: OP_NOP,       cond: COND_OUT_FULL, target: STEP_OUT_WAIT};
            STEP_MIX:       w = '{op: OP_MIX,       cond: COND_ALWAYS,   target: STEP_IDLE};
            default:        w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/hpdd_if.sv @@
// Handshake channels of the heading PI core: item, result and config write.
// Depends on nothing; compiled after hpdd_pkg.
`timescale 1ns / 1ps

interface hpdd_item_if;
    logic               valid;
    logic               ready;
    logic signed [9:0]  target_heading;
    logic [14:0]        measured_heading;
    logic signed [13:0] distance_difference;
    logic               turning;
    logic signed [1:0]  drive_direction;
    logic               stop_all;

    modport source (output valid, target_heading, measured_heading, distance_difference,
                    turning, drive_direction, stop_all, input ready);
    modport sink   (input valid, target_heading, measured_heading, distance_difference,
                    turning, drive_direction, stop_all, output ready);
endinterface

interface hpdd_result_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] correction;
    logic [15:0]        left_level;
    logic [15:0]        right_level;
    logic [3:0]         direction_pins;

    modport source (output valid, correction, left_level, right_level, direction_pins,
                    input ready);
    modport sink   (input valid, correction, left_level, right_level, direction_pins,
                    output ready);
endinterface

interface hpdd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/hpdd_divider.sv @@
// Serial restoring divider, one quotient bit per cycle, 32-bit by 16-bit unsigned.
// Depends on hpdd_pkg.
`timescale 1ns / 1ps

module hpdd_divider import hpdd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [16:0] shifted;
    logic [17:0] diff;
    logic        ge;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = !diff[17];

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (req.start)
        begin
            cnt_next = 6'(DIV_STEPS);
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 6'd1;
            quo_next = {quo_reg[30:0], ge};
            rem_next = ge ? diff[15:0] : shifted[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = (cnt_reg != '0);
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/hpdd_sequencer.sv @@
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on hpdd_pkg (ucode_rom, op/cond codes).
`timescale 1ns / 1ps

module hpdd_sequencer import hpdd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output op_t   op
);

    step_t  pc_reg, pc_next;
    ucode_t word;
    logic   jump;

    assign word = ucode_rom(pc_reg);
    assign op   = word.op;

    always_comb
    begin
        case (word.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_ITEM:  jump = !stat.item_valid;
            COND_DIV_BUSY: jump = stat.div_busy;
            COND_DEADBAND: jump = stat.deadband;
            COND_OUT_FULL: jump = stat.out_full;
            default:       jump = 1'b1;
        endcase
        pc_next = jump ? word.target : pc_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

@@ rtl/hpdd_datapath.sv @@
// Datapath of the heading PI core: operand registers, shared multiplier,
// integral state and the output word register. Depends on hpdd_pkg, hpdd_if.
`timescale 1ns / 1ps

module hpdd_datapath import hpdd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  op_t                  op,
    input  cfg_regs_t            regs,
    hpdd_item_if.sink            item,
    hpdd_result_if.source        result,
    output div_req_t             div_req,
    input  div_rsp_t             div_rsp,
    output stat_t                stat
);

    // latched item
    logic signed [9:0]  target_reg, target_next;
    logic [14:0]        meas_reg, meas_next;
    logic signed [13:0] dist_reg, dist_next;
    logic               turn_reg, turn_next;
    logic [1:0]         dir_reg, dir_next;
    logic               stop_reg, stop_next;
    // working values
    logic signed [31:0] wa_reg, wa_next;
    logic [16:0]        modq_reg, modq_next;
    logic [8:0]         modr_reg, modr_next;
    logic signed [14:0] e_reg, e_next;
    logic [13:0]        mag_reg, mag_next;
    logic signed [30:0] prod_reg, prod_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [24:0] iterm_reg, iterm_next;
    logic signed [31:0] sum_reg, sum_next;
    logic signed [17:0] corr_reg, corr_next;
    // output word
    logic               rv_reg, rv_next;
    logic signed [17:0] rcorr_reg, rcorr_next;
    logic [15:0]        rleft_reg, rleft_next;
    logic [15:0]        rright_reg, rright_next;
    logic [3:0]         rpins_reg, rpins_next;

    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    logic [31:0]        raw_sum;
    logic [31:0]        d_term;
    logic [24:0]        mod_x;
    logic [49:0]        mod_prod;
    logic [24:0]        mod_qm;
    logic [24:0]        mod_rem;
    logic [14:0]        m_wrap;
    logic [15:0]        e_full, e_abs;
    logic signed [32:0] acc_sum;
    logic [31:0]        acc_abs;
    logic [23:0]        q_clamp;
    logic [24:0]        iterm_mag;
    logic signed [18:0] q_corr;
    logic signed [16:0] base;
    logic signed [18:0] left_sum, right_sum;
    logic signed [17:0] left_c, right_c;
    logic               deadband;

    function automatic logic signed [17:0] clamp_level(input logic signed [18:0] v);
        logic signed [17:0] r;
        if (v > 19'sd65520)
            r = 18'sd65520;
        else if (v < -19'sd65520)
            r = -18'sd65520;
        else
            r = v[17:0];
        return r;
    endfunction

    function automatic logic [15:0] level_mag(input logic signed [17:0] v);
        logic [17:0] a;
        a = v[17] ? 18'(-v) : v;
        return a[15:0];
    endfunction

    // shared multiplier for the distance, integral and proportional products, operands chosen by the op
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_MUL_D:
            begin
                mul_a = {{3{dist_reg[13]}}, dist_reg};
                mul_b = {1'b0, regs.distance_gain};
            end
            OP_MUL_I:
            begin
                mul_a = {{2{e_reg[14]}}, e_reg};
                mul_b = {1'b0, regs.integral_gain};
            end
            OP_MUL_P:
            begin
                mul_a = {{2{e_reg[14]}}, e_reg};
                mul_b = {1'b0, regs.proportional_gain};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign deadband = (mag_reg <= 14'(DEADBAND_FX));

    // raw error: target in fixed point minus measured, plus floored distance term
    assign d_term  = turn_reg ? 32'd0 : {{3{prod_reg[30]}}, prod_reg[30:2]};
    assign raw_sum = {{16{target_reg[9]}}, target_reg, 6'b0} - {17'd0, meas_reg} + d_term;

    // whole degrees made non-negative, then reduced modulo 360 by reciprocal multiply
    assign mod_x    = 25'({{6{wa_reg[31]}}, wa_reg[31:6]} + 32'(MOD_OFFSET));
    assign mod_prod = mod_x * MOD_RECIP;
    assign mod_qm   = {8'd0, modq_reg} * 25'(MOD_DIVISOR);
    assign mod_rem  = mod_x - mod_qm;

    // heading wrap from the whole-degree remainder and the fraction bits
    assign m_wrap = {modr_reg, wa_reg[5:0]};
    assign e_full = (m_wrap > 15'(HALF_FX)) ? ({1'b0, m_wrap} - 16'(PERIOD_FX))
                                            : {1'b0, m_wrap};
    assign e_abs  = e_full[15] ? 16'(-e_full) : e_full;

    assign acc_sum = {acc_reg[31], acc_reg} + {{2{prod_reg[30]}}, prod_reg};
    assign acc_abs = acc_reg[31] ? 32'(~acc_reg + 32'sd1) : acc_reg;

    assign q_clamp   = (div_rsp.quotient > 32'(INT_LIMIT_FX)) ? 24'(INT_LIMIT_FX)
                                                              : div_rsp.quotient[23:0];
    assign iterm_mag = {1'b0, q_clamp};

    // divide by 2^14, rounding toward zero
    assign q_corr = {sum_reg[31], sum_reg[31:14]}
                  + ((sum_reg[31] && (sum_reg[13:0] != '0)) ? 19'sd1 : 19'sd0);

    always_comb
    begin
        case (dir_reg)
            DIR_FWD:  base = {1'b0, regs.base_duty};
            DIR_NONE: base = '0;
            default:  base = 17'(-{1'b0, regs.base_duty});
        endcase
    end

    assign left_sum  = {{2{base[16]}}, base} + {corr_reg[17], corr_reg};
    assign right_sum = {{2{base[16]}}, base} - {corr_reg[17], corr_reg};
    assign left_c    = clamp_level(left_sum);
    assign right_c   = clamp_level(right_sum);

    always_comb
    begin
        target_next = target_reg;
        meas_next   = meas_reg;
        dist_next   = dist_reg;
        turn_next   = turn_reg;
        dir_next    = dir_reg;
        stop_next   = stop_reg;
        wa_next     = wa_reg;
        modq_next   = modq_reg;
        modr_next   = modr_reg;
        e_next      = e_reg;
        mag_next    = mag_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        iterm_next  = iterm_reg;
        sum_next    = sum_reg;
        corr_next   = corr_reg;
        rcorr_next  = rcorr_reg;
        rleft_next  = rleft_reg;
        rright_next = rright_reg;
        rpins_next  = rpins_reg;
        rv_next     = rv_reg && !result.ready;

        case (op)
            OP_LOAD:
            begin
                target_next = item.target_heading;
                meas_next   = item.measured_heading;
                dist_next   = item.distance_difference;
                turn_next   = item.turning;
                dir_next    = item.drive_direction;
                stop_next   = item.stop_all;
            end
            OP_MUL_D, OP_MUL_I, OP_MUL_P:
                prod_next = mul_p[30:0];
            OP_RAW:
                wa_next = raw_sum;
            OP_MOD_START:
                modq_next = mod_prod[49:MOD_SHIFT];
            OP_MOD_REM:
                modr_next = mod_rem[8:0];
            OP_WRAP:
            begin
                e_next   = e_full[14:0];
                mag_next = e_abs[13:0];
            end
            OP_ACC:
            begin
                iterm_next = '0;
                if (deadband)
                    acc_next = '0;
                else if (acc_sum[32] != acc_sum[31])
                    acc_next = acc_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                else
                    acc_next = acc_sum[31:0];
            end
            OP_ITERM:
                iterm_next = acc_reg[31] ? 25'(-iterm_mag) : iterm_mag;
            OP_SUM:
                sum_next = {prod_reg[30], prod_reg} + {iterm_reg[24], iterm_reg, 6'b0};
            OP_CORR:
            begin
                if (q_corr > 19'(CORR_LIMIT))
                    corr_next = 18'(CORR_LIMIT);
                else if (q_corr < -19'(CORR_LIMIT))
                    corr_next = 18'(-CORR_LIMIT);
                else
                    corr_next = q_corr[17:0];
            end
            OP_MIX:
            begin
                rv_next    = 1'b1;
                rcorr_next = corr_reg;
                if (stop_reg)
                begin
                    rleft_next  = '0;
                    rright_next = '0;
                    rpins_next  = 4'hf;
                end
                else
                begin
                    rleft_next  = level_mag(left_c);
                    rright_next = level_mag(right_c);
                    rpins_next  = {(left_c > 0) ? 2'b01 : 2'b10,
                                   (right_c > 0) ? 2'b10 : 2'b01};
                end
            end
            default:
            begin
                rv_next = rv_reg && !result.ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            rv_reg  <= rv_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        meas_reg   <= meas_next;
        dist_reg   <= dist_next;
        turn_reg   <= turn_next;
        dir_reg    <= dir_next;
        stop_reg   <= stop_next;
        wa_reg     <= wa_next;
        modq_reg   <= modq_next;
        modr_reg   <= modr_next;
        e_reg      <= e_next;
        mag_reg    <= mag_next;
        prod_reg   <= prod_next;
        iterm_reg  <= iterm_next;
        sum_reg    <= sum_next;
        corr_reg   <= corr_next;
        rcorr_reg  <= rcorr_next;
        rleft_reg  <= rleft_next;
        rright_reg <= rright_next;
        rpins_reg  <= rpins_next;
    end

    // divider request: integral / |error|
    assign div_req.start    = (op == OP_DIV_START);
    assign div_req.dividend = acc_abs;
    assign div_req.divisor  = {2'b00, mag_reg};

    assign stat.item_valid = item.valid;
    assign stat.div_busy   = div_rsp.busy;
    assign stat.deadband   = deadband;
    assign stat.out_full   = rv_reg && !result.ready;

    assign item.ready            = (op == OP_LOAD);
    assign result.valid          = rv_reg;
    assign result.correction     = rcorr_reg;
    assign result.left_level     = rleft_reg;
    assign result.right_level    = rright_reg;
    assign result.direction_pins = rpins_reg;

endmodule

@@ rtl/heading_pi_differential_drive_core.sv @@
// Top level of the heading PI controller with differential-drive mixer.
// Depends on hpdd_pkg, hpdd_if, hpdd_divider, hpdd_sequencer, hpdd_datapath.
`timescale 1ns / 1ps
`include "heading_pi_differential_drive_core_defines.svh"

//  channel  dir  word contents
//  -------  ---  ----------------------------------------------------------------
//  item     in   target, measured heading, distance diff, turning, direction, stop
//  result   out  correction, left level, right level, direction pins
//  cfg      in   register index (0..3) and 16-bit value, always ready
//
//  One item at a time; a word whose error lands in the 5 degree deadband skips
//  the divider. The 32-step serial divider that scales the integral by 1/|error|
//  sets the longer path; the modulo-360 wrap is a reciprocal multiply
//  over two steps. Reset clears the step counter, the integral, the output
//  valid and loads the register defaults. A finished word waits in the output
//  register; a new item is taken meanwhile and only the final mix step stalls.

module heading_pi_differential_drive_core import hpdd_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    hpdd_item_if.sink      item,
    hpdd_result_if.source  result,
    hpdd_cfg_if.sink       cfg
);

    cfg_regs_t regs_reg, regs_next;
    op_t       op;
    stat_t     stat;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    // configuration registers; the user must write them only while the core is idle, the block does not enforce it
    assign cfg.ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_DISTANCE_GAIN:     regs_next.distance_gain     = cfg.data;
                REG_INTEGRAL_GAIN:     regs_next.integral_gain     = cfg.data;
                REG_PROPORTIONAL_GAIN: regs_next.proportional_gain = cfg.data;
                REG_BASE_DUTY:         regs_next.base_duty         = cfg.data;
                default:               regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.distance_gain     <= 16'd256;
            regs_reg.integral_gain     <= 16'd0;
            regs_reg.proportional_gain <= 16'd256;
            regs_reg.base_duty         <= 16'd0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    // control program steps the datapath; jumps on item, divider, deadband and output state
    hpdd_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .op    (op)
    );

    hpdd_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .regs    (regs_reg),
        .item    (item),
        .result  (result),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .stat    (stat)
    );

    // integral scaling by 1/|error|
    hpdd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // no second item while one is in flight
    `HPDD_ASSERT_NEXT(a_one_item, item.valid && item.ready, !item.ready)
    // divider never restarted mid-run
    `HPDD_ASSERT_IMPL(a_div_idle_start, div_req.start, !div_rsp.busy)
    // divider runs right after a start, so the wait steps see it busy
    `HPDD_ASSERT_NEXT(a_div_runs, div_req.start, div_rsp.busy)
    // mix never overwrites a word not yet taken
    `HPDD_ASSERT_IMPL(a_no_overwrite, op == OP_MIX, !result.valid)

endmodule
